// ----- hdl/srwg_pkg.sv -----
// Shared constants, types and kernel coefficients for the sharp resampling weight generator.
package srwg_pkg;

    localparam int RADIUS_DEF  = 5;
    localparam int STEPS_DEF   = 2000;
    localparam int OFF_W       = 11;
    localparam int POS_W       = 4;
    localparam int WT_W        = 18;
    // Rounded weight magnitudes stay below 2^17 for every piece of the kernel.
    localparam int QUO_W       = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int COEF_W      = 13;

    typedef enum logic [2:0] {
        PC_CORE,
        PC_LOBE1,
        PC_LOBE2,
        PC_LOBE3,
        PC_TAIL,
        PC_ZERO
    } t_piece;

    typedef logic signed [COEF_W-1:0] t_coef;

    // Each piece numerator over 1152*S*S is c_dd*d*d + c_ds*d*S + c_ss*S*S.
    typedef struct packed {
        t_coef c_dd;
        t_coef c_ds;
        t_coef c_ss;
    } t_coefs;

    function automatic t_coefs piece_coefs(t_piece p);
        t_coefs c;
        unique case (p)
            PC_CORE: begin
                c.c_dd = -13'sd1912; c.c_ds = 13'sd0;     c.c_ss = 13'sd1154;
            end
            PC_LOBE1: begin
                c.c_dd = 13'sd1120;  c.c_ds = -13'sd3032; c.c_ss = 13'sd1912;
            end
            PC_LOBE2: begin
                c.c_dd = -13'sd192;  c.c_ds = 13'sd904;   c.c_ss = -13'sd1040;
            end
            PC_LOBE3: begin
                c.c_dd = 13'sd32;    c.c_ds = -13'sd216;  c.c_ss = 13'sd360;
            end
            PC_TAIL: begin
                c.c_dd = -13'sd4;    c.c_ds = 13'sd36;    c.c_ss = -13'sd81;
            end
            default: begin
                c.c_dd = 13'sd0;     c.c_ds = 13'sd0;     c.c_ss = 13'sd0;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/sharp_resampling_weight_generator_core.sv -----
// Top level of the sharp resampling weight generator: offset queue, tap sequencer and weight pipe.
//
// Usage: each input word carries one sub-pixel offset in steps of 1/STEPS_PER_UNIT
// pixel on i_offset_steps, qualified by i_in_valid and held off by o_in_stall. For
// every offset the block returns 2*RADIUS+1 output words, leftmost tap first, each
// with its tap position and a signed weight in units of 2^-16; o_last_tap marks the
// final word of the run. The output channel is qualified by o_out_valid and held
// off by i_out_stall.
// Throughput: one output word per cycle while i_out_stall is low and offsets keep
// coming; the tap sequencer, which issues one tap per cycle, sets it.
// Path: queue memory, next-offset register, sequencer, then the distance, product,
// term, dividend, reciprocal product, estimate, correction and output registers.
// Offsets wait in a four-entry queue memory, so the input keeps flowing while
// results are still being taken; o_in_stall rises only when that queue is full.
// A stall on the output freezes the whole weight pipe in place; nothing is dropped.
// Reset empties the queue and the pipe; there is no other state and no clearing pass.
module sharp_resampling_weight_generator_core
    import srwg_pkg::*;
#(
    parameter int RADIUS         = RADIUS_DEF,
    parameter int STEPS_PER_UNIT = STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [OFF_W-1:0]        i_offset_steps,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [POS_W-1:0]        o_tap_position,
    output logic signed [WT_W-1:0]  o_weight,
    output logic                    o_last_tap
);

    // Distance index range and derived widths.
    localparam int MAX_IDX = (9 * STEPS_PER_UNIT) / 2 + 1;
    localparam int DW      = $clog2(MAX_IDX + 1);
    localparam int CW      = DW + 2;
    localparam int SW      = $clog2(STEPS_PER_UNIT + 1);
    localparam int DDW     = 2 * DW;
    localparam int DSW     = DW + SW;
    localparam logic [63:0] SS = 64'(STEPS_PER_UNIT) * 64'(STEPS_PER_UNIT);
    localparam int SSW     = $clog2(SS + 64'd1);
    localparam int TW      = SSW + 15;
    localparam int NW      = TW + 2;
    localparam int XW      = NW + 11;
    localparam logic [XW-1:0] DEN = XW'(64'd9 * SS);
    localparam logic [XW-1:0] D2X = XW'(64'd18 * SS);

    // Division by the constant 18*S*S. The top bits of the dividend times a scaled
    // reciprocal give the quotient or one less; a compare against the remainder
    // settles which.
    localparam int CLD = $clog2(D2X);
    localparam int LSH = CLD - 3;
    localparam int HW  = XW - LSH;
    localparam int RW  = XW + 3 - CLD;
    localparam int RSH = HW + 2;
    localparam int PW  = HW + RW;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << (XW + 2)) / 64'(D2X));

    // Tap sequencing.
    localparam int TAPS = 2 * RADIUS + 1;
    localparam int TPW  = $clog2(TAPS);
    localparam logic [TPW-1:0] LAST_TAP = TPW'(TAPS - 1);
    localparam int TSW  = $clog2(RADIUS * STEPS_PER_UNIT + MAX_IDX + 2 ** OFF_W) + 1;
    localparam logic signed [TSW-1:0] TS_START = TSW'(-(RADIUS * STEPS_PER_UNIT));
    localparam logic signed [TSW-1:0] TS_STEP  = TSW'(STEPS_PER_UNIT);

    // Offset queue.
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [OFF_W-1:0] r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             r_next_valid;
    logic [OFF_W-1:0] r_next_off;

    // Sequencer.
    logic                  r_busy;
    logic [TPW-1:0]        r_tap;
    logic [OFF_W-1:0]      r_off;
    logic signed [TSW-1:0] r_ts;

    // Distance stage.
    logic            r_s0_valid;
    logic [DW-1:0]   r_s0_d;
    logic [TPW-1:0]  r_s0_pos;
    logic            r_s0_last;

    // Product stage.
    logic            r_s1_valid;
    logic [DDW-1:0]  r_s1_dd;
    logic [DSW-1:0]  r_s1_ds;
    t_piece          r_s1_piece;
    logic [TPW-1:0]  r_s1_pos;
    logic            r_s1_last;

    // Term stage.
    logic                 r_s2_valid;
    logic signed [TW-1:0] r_s2_ta;
    logic signed [TW-1:0] r_s2_tb;
    logic signed [TW-1:0] r_s2_tc;
    logic [TPW-1:0]       r_s2_pos;
    logic                 r_s2_last;

    // Dividend stage.
    logic            r_x_valid;
    logic [XW-1:0]   r_x;
    logic            r_x_neg;
    logic [TPW-1:0]  r_x_pos;
    logic            r_x_last;

    // Reciprocal product stage.
    logic            r_m_valid;
    logic [PW-1:0]   r_m_prod;
    logic [XW-1:0]   r_m_x;
    logic            r_m_neg;
    logic [TPW-1:0]  r_m_pos;
    logic            r_m_last;

    // Quotient estimate stage.
    logic             r_e_valid;
    logic [QUO_W-1:0] r_e_q;
    logic [XW-1:0]    r_e_qd;
    logic [XW-1:0]    r_e_x;
    logic             r_e_neg;
    logic [TPW-1:0]   r_e_pos;
    logic             r_e_last;

    // Corrected quotient stage.
    logic             r_f_valid;
    logic [QUO_W-1:0] r_f_q;
    logic             r_f_neg;
    logic [TPW-1:0]   r_f_pos;
    logic             r_f_last;

    // Output register.
    logic                   r_o_valid;
    logic [TPW-1:0]         r_o_pos;
    logic signed [WT_W-1:0] r_o_weight;
    logic                   r_o_last;

    logic                  en;
    logic                  push;
    logic                  pop;
    logic                  at_last;
    logic                  consume;
    logic signed [TSW-1:0] diff;
    logic [TSW-1:0]        dist_abs;
    logic [DW-1:0]         n_d;
    logic [CW-1:0]         twod;
    t_piece                n_piece;
    t_coefs                coefs;
    logic signed [TW-1:0]  n_ta;
    logic signed [TW-1:0]  n_tb;
    logic signed [TW-1:0]  n_tc;
    logic signed [NW-1:0]  numer;
    logic [NW-1:0]         numer_mag;
    logic [XW-1:0]         n_x;
    logic [QUO_W-1:0]      q_est;

    assign o_in_stall     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_out_valid    = r_o_valid;
    assign o_tap_position = POS_W'(r_o_pos);
    assign o_weight       = r_o_weight;
    assign o_last_tap     = r_o_last;

    always_comb begin
        // The pipe advances unless a finished word is held by the receiver.
        en      = !r_o_valid || !i_out_stall;
        push    = i_in_valid && !o_in_stall;
        pop     = (r_count != '0) && !r_next_valid;
        at_last = (r_tap == LAST_TAP);
        // A waiting offset is loaded when the sequencer is idle or on its final tap.
        consume = en && r_next_valid && (!r_busy || at_last);

        diff     = r_ts - $signed(TSW'(r_off));
        dist_abs = (diff < 0) ? TSW'(-diff) : TSW'(diff);
        n_d      = (dist_abs > TSW'(MAX_IDX)) ? DW'(MAX_IDX) : dist_abs[DW-1:0];

        // Each piece includes its upper boundary.
        twod = CW'({r_s0_d, 1'b0});
        if (twod <= CW'(STEPS_PER_UNIT)) begin
            n_piece = PC_CORE;
        end else if (twod <= CW'(3 * STEPS_PER_UNIT)) begin
            n_piece = PC_LOBE1;
        end else if (twod <= CW'(5 * STEPS_PER_UNIT)) begin
            n_piece = PC_LOBE2;
        end else if (twod <= CW'(7 * STEPS_PER_UNIT)) begin
            n_piece = PC_LOBE3;
        end else if (twod <= CW'(9 * STEPS_PER_UNIT)) begin
            n_piece = PC_TAIL;
        end else begin
            n_piece = PC_ZERO;
        end

        coefs = piece_coefs(r_s1_piece);
        n_ta  = TW'(coefs.c_dd * $signed({1'b0, r_s1_dd}));
        n_tb  = TW'(coefs.c_ds * $signed({1'b0, r_s1_ds}));
        n_tc  = TW'(coefs.c_ss * $signed({1'b0, SS[SSW-1:0]}));

        // Rounded quotient is (2*|N|*512 + den) / (2*den), ties away from zero.
        numer     = NW'(r_s2_ta) + NW'(r_s2_tb) + NW'(r_s2_tc);
        numer_mag = (numer < 0) ? NW'(-numer) : NW'(numer);
        n_x       = (XW'(numer_mag) << 10) + DEN;

        // Never above the true quotient and at most one below it.
        q_est = r_m_prod[RSH +: QUO_W];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
            r_next_valid <= 1'b0;
            r_busy       <= 1'b0;
            r_tap        <= '0;
            r_s0_valid   <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_x_valid    <= 1'b0;
            r_m_valid    <= 1'b0;
            r_e_valid    <= 1'b0;
            r_f_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(push) - CNT_W'(pop);

            if (pop) begin
                r_next_valid <= 1'b1;
            end else if (consume) begin
                r_next_valid <= 1'b0;
            end

            if (en) begin
                if (consume) begin
                    r_busy <= 1'b1;
                    r_tap  <= '0;
                end else if (r_busy) begin
                    if (at_last) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_tap <= r_tap + TPW'(1);
                    end
                end
                r_s0_valid <= r_busy;
                r_s1_valid <= r_s0_valid;
                r_s2_valid <= r_s1_valid;
                r_x_valid  <= r_s2_valid;
                r_m_valid  <= r_x_valid;
                r_e_valid  <= r_m_valid;
                r_f_valid  <= r_e_valid;
                r_o_valid  <= r_f_valid;
            end
        end
    end

    // Payload path: queue memory, sequencer data and the weight pipe.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= i_offset_steps;
        end
        if (pop) begin
            r_next_off <= r_queue[r_rd_ptr];
        end

        if (en) begin
            if (consume) begin
                r_off <= r_next_off;
                r_ts  <= TS_START;
            end else if (r_busy) begin
                r_ts <= r_ts + TS_STEP;
            end

            r_s0_d    <= n_d;
            r_s0_pos  <= r_tap;
            r_s0_last <= at_last;

            r_s1_dd    <= DDW'(r_s0_d) * DDW'(r_s0_d);
            r_s1_ds    <= DSW'(r_s0_d) * DSW'(STEPS_PER_UNIT);
            r_s1_piece <= n_piece;
            r_s1_pos   <= r_s0_pos;
            r_s1_last  <= r_s0_last;

            r_s2_ta   <= n_ta;
            r_s2_tb   <= n_tb;
            r_s2_tc   <= n_tc;
            r_s2_pos  <= r_s1_pos;
            r_s2_last <= r_s1_last;

            r_x      <= n_x;
            r_x_neg  <= (numer < 0);
            r_x_pos  <= r_s2_pos;
            r_x_last <= r_s2_last;

            r_m_prod <= PW'(r_x[XW-1:LSH]) * PW'(RECIP);
            r_m_x    <= r_x;
            r_m_neg  <= r_x_neg;
            r_m_pos  <= r_x_pos;
            r_m_last <= r_x_last;

            r_e_q    <= q_est;
            r_e_qd   <= XW'(q_est) * D2X;
            r_e_x    <= r_m_x;
            r_e_neg  <= r_m_neg;
            r_e_pos  <= r_m_pos;
            r_e_last <= r_m_last;

            // A remainder of at least one divisor means the estimate was one short.
            r_f_q    <= (r_e_x >= r_e_qd + D2X) ? r_e_q + QUO_W'(1) : r_e_q;
            r_f_neg  <= r_e_neg;
            r_f_pos  <= r_e_pos;
            r_f_last <= r_e_last;

            r_o_pos    <= r_f_pos;
            r_o_last   <= r_f_last;
            r_o_weight <= r_f_neg ? $signed(-WT_W'(r_f_q)) : $signed(WT_W'(r_f_q));
        end
    end

endmodule

// ----- test/srwg_checker.sv -----
// Checker for the sharp resampling weight generator: predicts every tap word and compares it.
module srwg_checker
    import srwg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [OFF_W-1:0]        i_offset_steps,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [POS_W-1:0]        i_tap_position,
    input  logic signed [WT_W-1:0]  i_weight,
    input  logic                    i_last_tap,
    output int                      o_fail_count,
    output int                      o_words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint STEPS    = STEPS_DEF;
    localparam longint MAX_DIST = (9 * STEPS) / 2 + 1;

    typedef struct {
        logic [POS_W-1:0]       pos;
        logic signed [WT_W-1:0] weight;
        logic                   last;
    } t_tap_word;

    // Tap words still owed by the block, oldest first.
    t_tap_word taps_due[$];

    initial begin
        o_fail_count = 0;
        o_words_due  = 0;
    end

    // Every piece includes its upper end, so a boundary distance takes the lower piece.
    function automatic t_piece piece_of(input longint dist_idx);
        if (2 * dist_idx <= STEPS)     return PC_CORE;
        if (2 * dist_idx <= 3 * STEPS) return PC_LOBE1;
        if (2 * dist_idx <= 5 * STEPS) return PC_LOBE2;
        if (2 * dist_idx <= 7 * STEPS) return PC_LOBE3;
        if (2 * dist_idx <= 9 * STEPS) return PC_TAIL;
        return PC_ZERO;
    endfunction

    // Kernel value times 1152*S*S, exact.
    function automatic longint mks_numerator(input longint dist_idx);
        longint dd;
        longint ds;
        longint ss;
        longint q;
        dd = dist_idx * dist_idx;
        ds = dist_idx * STEPS;
        ss = STEPS * STEPS;
        q  = 2 * dist_idx - 9 * STEPS;
        case (piece_of(dist_idx))
            PC_CORE:  return 1154 * ss - 1912 * dd;
            PC_LOBE1: return 1120 * dd - 3032 * ds + 1912 * ss;
            PC_LOBE2: return -192 * dd + 904 * ds - 1040 * ss;
            PC_LOBE3: return 32 * dd - 216 * ds + 360 * ss;
            PC_TAIL:  return -(q * q);
            default:  return 0;
        endcase
    endfunction

    // Scale to units of 2^-16 and round to nearest, halfway away from zero.
    function automatic logic signed [WT_W-1:0] weight_of(input longint dist_idx);
        longint scaled;
        longint den;
        longint mag;
        longint rounded;
        scaled  = mks_numerator(dist_idx) * 512;
        den     = 9 * STEPS * STEPS;
        mag     = (scaled < 0) ? -scaled : scaled;
        rounded = (2 * mag + den) / (2 * den);
        if (scaled < 0)
            rounded = -rounded;
        return rounded[WT_W-1:0];
    endfunction

    task automatic queue_taps(input logic [OFF_W-1:0] offset);
        int        tap;
        longint    dist_idx;
        t_tap_word word;
        for (tap = -RADIUS_DEF; tap <= RADIUS_DEF; tap++) begin
            dist_idx = longint'(tap) * STEPS - longint'(offset);
            if (dist_idx < 0)
                dist_idx = -dist_idx;
            if (dist_idx > MAX_DIST)
                dist_idx = MAX_DIST;
            word.pos    = POS_W'(tap + RADIUS_DEF);
            word.weight = weight_of(dist_idx);
            word.last   = (tap == RADIUS_DEF);
            taps_due.push_back(word);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_tap_word want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (taps_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word pos=%0d weight=%0d",
                                              i_tap_position, i_weight));
                end else begin
                    want = taps_due.pop_front();
                    if (i_tap_position !== want.pos)
                        report_mismatch($sformatf("tap_position got %0d want %0d",
                                                  i_tap_position, want.pos));
                    if (i_weight !== want.weight)
                        report_mismatch($sformatf("weight at pos %0d got %0d want %0d",
                                                  want.pos, i_weight, want.weight));
                    if (i_last_tap !== want.last)
                        report_mismatch($sformatf("last_tap at pos %0d got %0b want %0b",
                                                  want.pos, i_last_tap, want.last));
                end
            end
            if (i_in_valid && !i_in_stall)
                queue_taps(i_offset_steps);
        end
        o_words_due = taps_due.size();
    end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the sharp resampling weight generator: clock, reset, offset stimulus, verdict.
module tb_top;
    import srwg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The limit lies far above what the slowest correct run needs.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 48;
    localparam int PHASE_ITEMS  = 85;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   in_valid  = 1'b0;
    logic [OFF_W-1:0]       offset    = '0;
    logic                   out_stall = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [POS_W-1:0]       o_tap_position;
    logic signed [WT_W-1:0] o_weight;
    logic                   o_last_tap;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int cycle_count = 0;
    int fail_count;
    int words_due;

    // Zero and full scale, exact piece boundaries (offset 1000 puts every tap but the leftmost on one),
    // offsets past 1999, and alternating bit patterns.
    int edge_offsets [20] = '{0, 1, 2, 1999, 2047, 1000, 999, 1001, 500, 1500,
                              2000, 2046, 1024, 1023, 1365, 682, 250, 750, 1750, 1998};

    sharp_resampling_weight_generator_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_offset_steps (offset),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_tap_position (o_tap_position),
        .o_weight       (o_weight),
        .o_last_tap     (o_last_tap)
    );

    srwg_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (o_in_stall),
        .i_offset_steps (offset),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .i_tap_position (o_tap_position),
        .i_weight       (o_weight),
        .i_last_tap     (o_last_tap),
        .o_fail_count   (fail_count),
        .o_words_due    (words_due)
    );

    always #5 i_clk = ~i_clk;

    // The receiver stalls on its own schedule, independent of the output valid.
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly in-range offsets; one in ten covers the full 11-bit field.
    function automatic logic [OFF_W-1:0] random_offset();
        if ($urandom_range(9) == 0)
            return OFF_W'($urandom_range((1 << OFF_W) - 1));
        return OFF_W'($urandom_range(STEPS_DEF - 1));
    endfunction

    // Presents one offset word, after a random gap, and holds it until it is taken.
    task automatic send_offset(input logic [OFF_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        offset   <= value;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    initial begin
        int phase;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (edge_offsets[k])
            send_offset(OFF_W'(edge_offsets[k]));

        // Idling phases: none, sender only, receiver only, both.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 74; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            repeat (PHASE_ITEMS)
                send_offset(random_offset());
        end
        in_valid <= 1'b0;

        // Sample the checker away from the clock edge so its update has settled.
        do
            @(negedge i_clk);
        while (words_due != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        if (fail_count == 0 && words_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
